// ===== design/jmsf_pkg.sv =====
// Shared types and constants for the JPEG metadata segment filter.
// No dependencies; imported by every module of the block.
package jmsf_pkg;

   // Counter width for written and dropped byte counts (16..64)
   localparam int COUNT_WIDTH = 32;
   // Depth of the action queue between front and back
   localparam int QDEPTH      = 4;
   localparam int QPTR_W      = $clog2(QDEPTH);
   localparam int MAX_BEATS   = 4;
   localparam int BEAT_W      = $clog2(MAX_BEATS);

   // Command codes
   localparam logic CMD_DATA = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // Result kinds
   localparam logic KIND_BYTE    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Status codes
   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_BAD_START = 3'd1;
   localparam logic [2:0] STAT_DESYNC    = 3'd2;
   localparam logic [2:0] STAT_BAD_LEN   = 3'd3;
   localparam logic [2:0] STAT_SHORT     = 3'd4;

   // Marker bytes
   localparam logic [7:0] MK_FILL = 8'hFF;
   localparam logic [7:0] MK_SOI  = 8'hD8;
   localparam logic [7:0] MK_SOS  = 8'hDA;
   localparam logic [7:0] MK_EOI  = 8'hD9;
   localparam logic [7:0] MK_RST0 = 8'hD0;
   localparam logic [7:0] MK_RST7 = 8'hD7;
   localparam logic [7:0] MK_APP1 = 8'hE1;
   localparam logic [7:0] MK_APP2 = 8'hE2;
   localparam logic [7:0] MK_APPF = 8'hEF;
   localparam logic [7:0] MK_COM  = 8'hFE;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  out_byte;
      logic [2:0]  status;
      logic [15:0] removed_segments;
      logic [31:0] bytes_written;
      logic [31:0] removed_bytes;
      logic        last;
   } rsp_type;

   // One queued action: up to four output bytes, or one summary
   typedef struct packed {
      logic                            is_summary;
      logic [BEAT_W-1:0]               beat_last;
      logic [MAX_BEATS-1:0][7:0]       bytes;
      logic [2:0]                      status;
      logic [15:0]                     removed_segments;
      logic [31:0]                     bytes_written;
      logic [31:0]                     removed_bytes;
   } entry_type;

   function automatic logic [COUNT_WIDTH-1:0] sat_add(
      input logic [COUNT_WIDTH-1:0] a,
      input logic [16:0]            b
   );
      logic [COUNT_WIDTH+1:0] s;
      s = (COUNT_WIDTH+2)'(a) + (COUNT_WIDTH+2)'(b);
      if (s[COUNT_WIDTH+1:COUNT_WIDTH] != 2'b00) return '1;
      return s[COUNT_WIDTH-1:0];
   endfunction

   function automatic logic [31:0] clip32(input logic [COUNT_WIDTH-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      if (w[63:32] != 32'd0) return 32'hFFFF_FFFF;
      return w[31:0];
   endfunction

   function automatic logic is_meta(input logic [7:0] m);
      return (m == MK_COM) || (m == MK_APP1) || ((m >= MK_APP2) && (m <= MK_APPF));
   endfunction

endpackage

// ===== design/jmsf_front.sv =====
// Front end: accepts input beats, runs the marker parser, keeps counters
// and queues one action per beat that yields results. Uses jmsf_pkg.
module jmsf_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  jmsf_pkg::req_type  req_data,
   output logic               q_push,
   output jmsf_pkg::entry_type q_entry,
   input  logic               q_full
);
   import jmsf_pkg::*;

   typedef enum logic [9:0] {
      PH_SOI_HI   = 10'b00_0000_0001,
      PH_SOI_LO   = 10'b00_0000_0010,
      PH_EXPECT   = 10'b00_0000_0100,
      PH_MARKER   = 10'b00_0000_1000,
      PH_LEN_HI   = 10'b00_0001_0000,
      PH_LEN_LO   = 10'b00_0010_0000,
      PH_PAYLOAD  = 10'b00_0100_0000,
      PH_VERBATIM = 10'b00_1000_0000,
      PH_DONE     = 10'b01_0000_0000,
      PH_ERROR    = 10'b10_0000_0000
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [7:0]             held_marker_ff, held_marker_in;
   logic [7:0]             length_high_ff, length_high_in;
   logic [15:0]            payload_left_ff, payload_left_in;
   logic                   dropping_ff, dropping_in;
   logic [2:0]             error_code_ff, error_code_in;
   logic [15:0]            removed_ff, removed_in;
   logic [COUNT_WIDTH-1:0] written_ff, written_in;
   logic [COUNT_WIDTH-1:0] dropped_ff, dropped_in;

   logic                   accept;
   logic                   is_end;
   logic [2:0]             nbytes;
   logic [15:0]            seg_len;
   logic [2:0]             fin_status;
   logic [7:0]             b;

   assign full   = q_full;
   assign accept = push && !q_full;
   assign is_end = req_data.command == CMD_END;
   assign b      = req_data.data_byte;
   assign seg_len = {length_high_ff, b};

   always_comb begin
      case (phase_ff)
         PH_SOI_HI, PH_SOI_LO: fin_status = STAT_BAD_START;
         PH_LEN_HI, PH_LEN_LO: fin_status = STAT_BAD_LEN;
         PH_PAYLOAD:           fin_status = dropping_ff ? STAT_OK : STAT_SHORT;
         PH_ERROR:             fin_status = error_code_ff;
         default:              fin_status = STAT_OK;
      endcase
   end

   always_comb begin
      phase_in        = phase_ff;
      held_marker_in  = held_marker_ff;
      length_high_in  = length_high_ff;
      payload_left_in = payload_left_ff;
      dropping_in     = dropping_ff;
      error_code_in   = error_code_ff;
      removed_in      = removed_ff;
      dropped_in      = dropped_ff;
      nbytes          = 3'd0;
      q_entry         = '0;

      if (accept && is_end) begin
         q_entry.is_summary       = 1'b1;
         q_entry.status           = fin_status;
         q_entry.removed_segments = removed_ff;
         q_entry.bytes_written    = clip32(written_ff);
         q_entry.removed_bytes    = clip32(dropped_ff);
         phase_in        = PH_SOI_HI;
         held_marker_in  = '0;
         length_high_in  = '0;
         payload_left_in = '0;
         dropping_in     = 1'b0;
         error_code_in   = STAT_OK;
         removed_in      = '0;
         dropped_in      = '0;
      end else if (accept) begin
         case (phase_ff)
            PH_SOI_HI: begin
               if (b == MK_FILL) phase_in = PH_SOI_LO;
               else begin
                  phase_in      = PH_ERROR;
                  error_code_in = STAT_BAD_START;
               end
            end
            PH_SOI_LO: begin
               if (b == MK_SOI) begin
                  nbytes           = 3'd2;
                  q_entry.bytes[0] = MK_FILL;
                  q_entry.bytes[1] = MK_SOI;
                  phase_in         = PH_EXPECT;
               end else begin
                  phase_in      = PH_ERROR;
                  error_code_in = STAT_BAD_START;
               end
            end
            PH_EXPECT: begin
               if (b == MK_FILL) phase_in = PH_MARKER;
               else begin
                  phase_in      = PH_ERROR;
                  error_code_in = STAT_DESYNC;
               end
            end
            PH_MARKER: begin
               if (b == MK_FILL) begin
                  // fill byte, stay
               end else if (b == MK_SOS || b == MK_EOI || (b >= MK_RST0 && b <= MK_RST7)) begin
                  nbytes           = 3'd2;
                  q_entry.bytes[0] = MK_FILL;
                  q_entry.bytes[1] = b;
                  if (b == MK_SOS)      phase_in = PH_VERBATIM;
                  else if (b == MK_EOI) phase_in = PH_DONE;
                  else                  phase_in = PH_EXPECT;
               end else begin
                  held_marker_in = b;
                  dropping_in    = is_meta(b);
                  phase_in       = PH_LEN_HI;
               end
            end
            PH_LEN_HI: begin
               length_high_in = b;
               phase_in       = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               if (seg_len < 16'd2) begin
                  phase_in      = PH_ERROR;
                  error_code_in = STAT_BAD_LEN;
               end else begin
                  payload_left_in = seg_len - 16'd2;
                  if (dropping_ff) begin
                     if (removed_ff != 16'hFFFF) removed_in = removed_ff + 16'd1;
                     dropped_in = sat_add(dropped_ff, 17'(seg_len) + 17'd2);
                  end else begin
                     nbytes           = 3'd4;
                     q_entry.bytes[0] = MK_FILL;
                     q_entry.bytes[1] = held_marker_ff;
                     q_entry.bytes[2] = length_high_ff;
                     q_entry.bytes[3] = b;
                  end
                  phase_in = (seg_len == 16'd2) ? PH_EXPECT : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               if (!dropping_ff) begin
                  nbytes           = 3'd1;
                  q_entry.bytes[0] = b;
               end
               payload_left_in = payload_left_ff - 16'd1;
               if (payload_left_ff == 16'd1) phase_in = PH_EXPECT;
            end
            PH_VERBATIM: begin
               nbytes           = 3'd1;
               q_entry.bytes[0] = b;
            end
            default: begin
               // done or error: ignore data
            end
         endcase
         q_entry.beat_last = BEAT_W'(nbytes - 3'd1);
      end

      if (accept && is_end) written_in = '0;
      else                  written_in = sat_add(written_ff, 17'(nbytes));

      q_push = accept && (is_end || nbytes != 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_SOI_HI;
         held_marker_ff  <= '0;
         length_high_ff  <= '0;
         payload_left_ff <= '0;
         dropping_ff     <= 1'b0;
         error_code_ff   <= STAT_OK;
         removed_ff      <= '0;
         written_ff      <= '0;
         dropped_ff      <= '0;
      end else begin
         phase_ff        <= phase_in;
         held_marker_ff  <= held_marker_in;
         length_high_ff  <= length_high_in;
         payload_left_ff <= payload_left_in;
         dropping_ff     <= dropping_in;
         error_code_ff   <= error_code_in;
         removed_ff      <= removed_in;
         written_ff      <= written_in;
         dropped_ff      <= dropped_in;
      end
   end

   // payload phase always has bytes left
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> payload_left_ff != 16'd0)
      else $error("payload phase with zero bytes left");

   // end of stream always queues its summary and returns to start
   assert property (@(posedge clock) disable iff (reset)
      accept && is_end |=> phase_ff == PH_SOI_HI && removed_ff == 16'd0)
      else $error("state not cleared after end of stream");

endmodule

// ===== design/jmsf_queue.sv =====
// Small action queue between front and back ends.
// Flop-based ring of QDEPTH entries; uses jmsf_pkg.
module jmsf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  jmsf_pkg::entry_type wr_entry,
   output logic                q_full,
   output logic                rd_valid,
   output jmsf_pkg::entry_type rd_entry,
   input  logic                rd_en
);
   import jmsf_pkg::*;

   entry_type          store_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;
   logic               do_wr, do_rd;

   assign q_full   = count_ff == (QPTR_W+1)'(QDEPTH);
   assign rd_valid = count_ff != '0;
   assign rd_entry = store_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !q_full;
   assign do_rd    = rd_en && rd_valid;

   always_comb begin
      wr_ptr_in = do_wr ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(do_wr) - (QPTR_W+1)'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (do_wr) store_ff[wr_ptr_ff] <= wr_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !q_full)
      else $error("write to full action queue");

   assert property (@(posedge clock) disable iff (reset)
      rd_en |-> rd_valid)
      else $error("read from empty action queue");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_W+1)'(QDEPTH))
      else $error("action queue count overflow");

endmodule

// ===== design/jmsf_back.sv =====
// Back end: expands queued actions into result beats, one per cycle while
// results are popped, into an output register. Uses jmsf_pkg.
module jmsf_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  jmsf_pkg::entry_type q_entry,
   output logic                q_pop,
   output logic                empty,
   input  logic                pop,
   output jmsf_pkg::rsp_type   rsp_data
);
   import jmsf_pkg::*;

   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;
   logic [BEAT_W-1:0] beat_ff, beat_in;
   logic              load;
   logic              take;

   assign take  = pop && out_valid_ff;
   assign load  = q_valid && (!out_valid_ff || take);
   assign q_pop = load && (beat_ff == q_entry.beat_last);

   always_comb begin
      out_in       = out_ff;
      beat_in      = beat_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
         out_in       = '0;
         if (q_entry.is_summary) begin
            out_in.kind             = KIND_SUMMARY;
            out_in.status           = q_entry.status;
            out_in.removed_segments = q_entry.removed_segments;
            out_in.bytes_written    = q_entry.bytes_written;
            out_in.removed_bytes    = q_entry.removed_bytes;
            out_in.last             = 1'b1;
         end else begin
            out_in.kind     = KIND_BYTE;
            out_in.out_byte = q_entry.bytes[beat_ff];
         end
         beat_in = q_pop ? '0 : BEAT_W'(beat_ff + 1'b1);
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         beat_ff      <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         beat_ff      <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

   // mid-action beat index only while an action is at the head
   assert property (@(posedge clock) disable iff (reset)
      beat_ff != '0 |-> q_valid)
      else $error("beat index set with no queued action");

   // a summary is a single beat
   assert property (@(posedge clock) disable iff (reset)
      q_valid && q_entry.is_summary |-> q_entry.beat_last == '0 && beat_ff == '0)
      else $error("summary action spans more than one beat");

endmodule

// ===== design/jpeg_metadata_segment_filter.sv =====
// Top level of the JPEG metadata segment filter.
// Instantiates jmsf_front, jmsf_queue and jmsf_back; uses jmsf_pkg.
//
//  channel   ports                        direction  accepted when
//  input     push, full, req_data         in         push && !full
//  result    empty, pop, rsp_data         out        pop && !empty
//
// Takes one input beat per cycle while the action queue has room; the
// parser decides each byte in the cycle it arrives.
// The result side drains one beat per cycle while pop is high; marker and
// header actions produce two or four beats, so a run of headers backs the
// 4-entry queue up and full rises until the back end catches up.
// Results pass through the queue store and then the output register.
// Reset is synchronous and active high; no clearing pass.
// Stalls on pop stop the back end only; input keeps flowing until the queue fills.
module jpeg_metadata_segment_filter (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  jmsf_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output jmsf_pkg::rsp_type rsp_data
);
   import jmsf_pkg::*;

   logic      q_push;
   entry_type q_wr_entry;
   logic      q_full;
   logic      q_valid;
   entry_type q_rd_entry;
   logic      q_pop;

   // parser and counters
   jmsf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .q_push   (q_push),
      .q_entry  (q_wr_entry),
      .q_full   (q_full)
   );

   // decouples parser from result drain
   jmsf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_push),
      .wr_entry (q_wr_entry),
      .q_full   (q_full),
      .rd_valid (q_valid),
      .rd_entry (q_rd_entry),
      .rd_en    (q_pop)
   );

   // beat expansion and output register
   jmsf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_entry  (q_rd_entry),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

// ===== bench/tb_jpeg_metadata_segment_filter.sv =====
// Self-checking bench for jpeg_metadata_segment_filter: byte beats in, filtered bytes
// and end-of-stream summaries out, checked against an in-bench parser model.
// Depends on jmsf_pkg (payload structs, codes, marker bytes) and the block's RTL.
module tb_jpeg_metadata_segment_filter;
   timeunit 1ns;
   timeprecision 1ps;

   import jmsf_pkg::*;

   // Parser position inside the file being filtered
   typedef enum logic [9:0] {
      ST_SOI_HI     = 10'b00_0000_0001,  // waiting for FF of the start marker
      ST_SOI_LO     = 10'b00_0000_0010,  // waiting for D8
      ST_MARK_START = 10'b00_0000_0100,  // a marker FF must come next
      ST_MARK_TYPE  = 10'b00_0000_1000,  // after FF: fill FF or the marker type
      ST_LEN_HI     = 10'b00_0001_0000,
      ST_LEN_LO     = 10'b00_0010_0000,
      ST_PAYLOAD    = 10'b00_0100_0000,
      ST_COPY       = 10'b00_1000_0000,  // after start of scan, bytes pass verbatim
      ST_DONE       = 10'b01_0000_0000,  // after end of image, data ignored
      ST_FAILED     = 10'b10_0000_0000   // after an error, data ignored
   } parse_state_type;

   // Scoreboard: runs the parser model on each accepted input beat and
   // matches accepted output beats against the oldest predicted one.
   class segment_filter_check;
      parse_state_type        st;
      logic [7:0]             marker_q;
      logic [7:0]             len_hi_q;
      logic [15:0]            left_q;
      bit                     drop_q;
      logic [2:0]             err_q;
      logic [15:0]            seg_cnt;
      logic [COUNT_WIDTH-1:0] out_cnt;
      logic [COUNT_WIDTH-1:0] drop_cnt;
      rsp_type                due_beats[$];
      int                     mismatch_cnt;

      function new();
         mismatch_cnt = 0;
         restart();
      endfunction

      function void restart();
         st       = ST_SOI_HI;
         marker_q = '0;
         len_hi_q = '0;
         left_q   = '0;
         drop_q   = 1'b0;
         err_q    = STAT_OK;
         seg_cnt  = '0;
         out_cnt  = '0;
         drop_cnt = '0;
      endfunction

      function logic [COUNT_WIDTH-1:0] bump_count(logic [COUNT_WIDTH-1:0] acc,
                                                   int unsigned inc);
         logic [COUNT_WIDTH+17:0] s;
         s = acc + inc;
         if (s[COUNT_WIDTH+17:COUNT_WIDTH] != '0) return '1;
         return s[COUNT_WIDTH-1:0];
      endfunction

      function logic [31:0] to32(logic [COUNT_WIDTH-1:0] acc);
         return (acc > 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(acc);
      endfunction

      function bit metadata_marker(logic [7:0] m);
         return m == MK_COM || m == MK_APP1 || (m >= MK_APP2 && m <= MK_APPF);
      endfunction

      function void emit_byte(logic [7:0] v);
         rsp_type s;
         s          = '0;
         s.kind     = KIND_BYTE;
         s.out_byte = v;
         due_beats.push_back(s);
         out_cnt = bump_count(out_cnt, 1);
      endfunction

      function void fail_with(logic [2:0] code);
         err_q = code;
         st    = ST_FAILED;
      endfunction

      function logic [2:0] end_status();
         case (st)
            ST_SOI_HI, ST_SOI_LO: return STAT_BAD_START;
            ST_LEN_HI, ST_LEN_LO: return STAT_BAD_LEN;
            ST_PAYLOAD:           return drop_q ? STAT_OK : STAT_SHORT;
            ST_FAILED:            return err_q;
            default:              return STAT_OK;
         endcase
      endfunction

      function void predict_beat(req_type r);
         rsp_type     s;
         logic [7:0]  b;
         logic [15:0] len;
         b = r.data_byte;
         if (r.command == CMD_END) begin
            s                  = '0;
            s.kind             = KIND_SUMMARY;
            s.status           = end_status();
            s.removed_segments = seg_cnt;
            s.bytes_written    = to32(out_cnt);
            s.removed_bytes    = to32(drop_cnt);
            s.last             = 1'b1;
            due_beats.push_back(s);
            restart();
            return;
         end
         case (st)
            ST_SOI_HI: begin
               if (b == MK_FILL) st = ST_SOI_LO;
               else fail_with(STAT_BAD_START);
            end
            ST_SOI_LO: begin
               if (b == MK_SOI) begin
                  emit_byte(MK_FILL);
                  emit_byte(MK_SOI);
                  st = ST_MARK_START;
               end else begin
                  fail_with(STAT_BAD_START);
               end
            end
            ST_MARK_START: begin
               if (b == MK_FILL) st = ST_MARK_TYPE;
               else fail_with(STAT_DESYNC);
            end
            ST_MARK_TYPE: begin
               if (b == MK_FILL) begin
                  // fill byte, stay
               end else if (b == MK_SOS) begin
                  emit_byte(MK_FILL);
                  emit_byte(b);
                  st = ST_COPY;
               end else if (b == MK_EOI || (b >= MK_RST0 && b <= MK_RST7)) begin
                  emit_byte(MK_FILL);
                  emit_byte(b);
                  st = (b == MK_EOI) ? ST_DONE : ST_MARK_START;
               end else begin
                  marker_q = b;
                  drop_q   = metadata_marker(b);
                  st       = ST_LEN_HI;
               end
            end
            ST_LEN_HI: begin
               len_hi_q = b;
               st       = ST_LEN_LO;
            end
            ST_LEN_LO: begin
               len = {len_hi_q, b};
               if (len < 16'd2) begin
                  fail_with(STAT_BAD_LEN);
               end else begin
                  left_q = len - 16'd2;
                  if (drop_q) begin
                     if (seg_cnt != 16'hFFFF) seg_cnt++;
                     drop_cnt = bump_count(drop_cnt, int'(len) + 2);
                  end else begin
                     emit_byte(MK_FILL);
                     emit_byte(marker_q);
                     emit_byte(len_hi_q);
                     emit_byte(b);
                  end
                  st = (left_q != 0) ? ST_PAYLOAD : ST_MARK_START;
               end
            end
            ST_PAYLOAD: begin
               if (!drop_q) emit_byte(b);
               if (left_q != 0) left_q--;
               if (left_q == 0) st = ST_MARK_START;
            end
            ST_COPY: emit_byte(b);
            default: ;
         endcase
      endfunction

      function void compare_beat(rsp_type got);
         rsp_type want;
         if (due_beats.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
               $display("%0t: result with nothing predicted: %p", $time, got);
            return;
         end
         want = due_beats.pop_front();
         if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
             got.status !== want.status ||
             got.removed_segments !== want.removed_segments ||
             got.bytes_written !== want.bytes_written ||
             got.removed_bytes !== want.removed_bytes || got.last !== want.last) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
               $display({"%0t: mismatch exp/got kind %0d/%0d byte %h/%h status %0d/%0d",
                         " segs %0d/%0d written %0d/%0d removed %0d/%0d last %0d/%0d"},
                        $time, want.kind, got.kind, want.out_byte, got.out_byte,
                        want.status, got.status, want.removed_segments,
                        got.removed_segments, want.bytes_written, got.bytes_written,
                        want.removed_bytes, got.removed_bytes, want.last, got.last);
         end
      endfunction
   endclass

   // Every input is known from time zero; reset starts high and is released by the main sequence
   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    push     = 1'b0;
   logic    pop      = 1'b0;
   req_type req_data = '0;
   logic    full;
   logic    empty;
   rsp_type rsp_data;

   segment_filter_check sb = new();

   req_type file_beats[$];   // beats of the file under construction
   int      sent_cnt  = 0;   // input beats accepted so far
   bit      tx_idle   = 1'b1;
   bit      rx_idle   = 1'b1;
   int      rx_hold   = 0;

   jpeg_metadata_segment_filter u_top (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   always #6 clock = ~clock;

   // Monitor: values read here are the ones from before the edge, since the
   // bench and the block both update through nonblocking assignments.
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) sb.predict_beat(req_data);
         if (pop && !empty) sb.compare_beat(rsp_data);
      end
   end

   // Result side: pop high by default, dropped for bursts of random length
   // that start only while rx_idle is set.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (rx_hold > 0) begin
         rx_hold = rx_hold - 1;
         pop <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
         rx_hold = $urandom_range(0, 8);
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   function automatic void put_byte(logic [7:0] b);
      req_type r;
      r.command   = CMD_DATA;
      r.data_byte = b;
      file_beats.push_back(r);
   endfunction

   // End of stream; the data field is don't-care, so it gets random bits
   function automatic void put_end();
      req_type r;
      r.command   = CMD_END;
      r.data_byte = 8'($urandom_range(0, 255));
      file_beats.push_back(r);
   endfunction

   function automatic void put_segment(logic [7:0] mk);
      int unsigned plen;
      logic [15:0] len;
      plen = $urandom_range(0, 5);
      len  = 16'(plen + 2);
      put_byte(mk);
      put_byte(len[15:8]);
      put_byte(len[7:0]);
      repeat (plen) put_byte(8'($urandom_range(0, 255)));
   endfunction

   // One random file. Mostly well formed with random content; a few are
   // noise or carry a bad start, and the rest end on a random kind of tail.
   function automatic void build_file();
      int unsigned pick;
      logic [7:0]  mk;
      logic [15:0] len;
      file_beats.delete();
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
         repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
         put_end();
         return;
      end
      put_byte(MK_FILL);
      put_byte(pick == 1 ? 8'($urandom_range(0, 255)) : MK_SOI);
      repeat ($urandom_range(0, 4)) begin
         put_byte(MK_FILL);
         if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) put_byte(MK_FILL);
         case ($urandom_range(0, 3))
            0: put_byte(8'(MK_RST0 + $urandom_range(0, 7)));
            1: put_segment($urandom_range(0, 1) ? MK_COM
                                                : 8'($urandom_range(MK_APP1, MK_APPF)));
            default: begin
               mk = 8'($urandom_range(0, 255));
               if (mk == MK_FILL || mk == MK_SOS || mk == MK_EOI ||
                   (mk >= MK_RST0 && mk <= MK_RST7))
                  mk = 8'hDB;
               put_segment(mk);
            end
         endcase
      end
      case ($urandom_range(0, 7))
         0: begin  // end of image, then junk that must be ignored
            put_byte(MK_FILL);
            put_byte(MK_EOI);
            repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(0, 255)));
         end
         1: begin  // start of scan, verbatim tail
            put_byte(MK_FILL);
            put_byte(MK_SOS);
            repeat ($urandom_range(0, 8)) put_byte(8'($urandom_range(0, 255)));
         end
         2: ;
         3: repeat ($urandom_range(1, 3)) put_byte(MK_FILL);  // stream stops mid-marker
         4: repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 254)));  // desync
         5: begin  // length below two, or stream cut inside the length
            put_byte(MK_FILL);
            put_byte(8'hC0);
            put_byte(8'h00);
            if ($urandom_range(0, 2) != 0) put_byte(8'($urandom_range(0, 1)));
         end
         6: begin  // stream cut inside a long payload, kept or dropped
            put_byte(MK_FILL);
            put_byte($urandom_range(0, 1) ? MK_APP1 : 8'hC4);
            len = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
            put_byte(len[15:8]);
            put_byte(len[7:0]);
            repeat ($urandom_range(0, 4)) put_byte(8'($urandom_range(0, 255)));
         end
         default: begin
            put_byte(MK_FILL);
            put_byte(MK_EOI);
         end
      endcase
      put_end();
   endfunction

   // Offer one beat and hold it until accepted, with an occasional gap first
   task automatic send_beat(input req_type r);
      if (tx_idle && $urandom_range(0, 4) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      sent_cnt++;
   endtask

   task automatic send_file();
      foreach (file_beats[i]) send_beat(file_beats[i]);
   endtask

   // Hold off the input until every predicted beat has been popped
   task automatic drain();
      push <= 1'b0;
      @(posedge clock);
      while (sb.due_beats.size() != 0) @(posedge clock);
   endtask

   initial begin
      int file_no;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty stream, bad first byte with ignored follower,
      // bad second byte, fill bytes + restart + empty and cut-off dropped
      // segments, then a desync right after the start marker.
      file_beats.delete();
      put_end();
      put_byte(8'h00); put_byte(8'hA5); put_end();
      put_byte(MK_FILL); put_byte(8'h00); put_end();
      put_byte(MK_FILL); put_byte(MK_SOI);
      put_byte(MK_FILL); put_byte(MK_FILL); put_byte(MK_RST0);
      put_byte(MK_FILL); put_byte(MK_APP1); put_byte(8'h00); put_byte(8'h02);
      put_byte(MK_FILL); put_byte(MK_COM); put_byte(8'h00); put_byte(8'h05);
      put_byte(8'h11); put_end();
      put_byte(MK_FILL); put_byte(MK_SOI); put_byte(8'h12); put_end();
      send_file();
      drain();

      // Random files; idling switches per file, and the tail runs at full rate
      file_no = 0;
      while (sent_cnt < 312) begin
         build_file();
         if (sent_cnt > 250) begin
            tx_idle = 1'b0;
            rx_idle = 1'b0;
         end else begin
            tx_idle = $urandom_range(0, 3) != 0;
            rx_idle = $urandom_range(0, 3) != 0;
         end
         send_file();
         file_no++;
         if (file_no == 6 || $urandom_range(0, 7) == 0) drain();
      end

      drain();
      repeat (20) @(posedge clock);
      if (sb.mismatch_cnt == 0 && sb.due_beats.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run
   initial begin
      #3_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
